// ----- sv/uer_pkg.sv -----
package uer_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLDOFF  = 3'd0,
    CFG_PULSE    = 3'd1,
    CFG_MIN_ECHO = 3'd2,
    CFG_MAX_ECHO = 3'd3,
    CFG_OBST_LIM = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] holdoff_us;
    logic [7:0]  pulse_us;
    logic [15:0] min_echo_us;
    logic [15:0] max_echo_us;
    logic [13:0] obstacle_limit;
  } cfg_t;

  localparam logic [15:0] HOLDOFF_RST  = 16'd60000;
  localparam logic [7:0]  PULSE_RST    = 8'd12;
  localparam logic [15:0] MIN_ECHO_RST = 16'd100;
  localparam logic [15:0] MAX_ECHO_RST = 16'd25000;
  localparam logic [13:0] OBST_LIM_RST = 14'd480;

  // 999 cm in 1/16 cm
  localparam logic [13:0] INVALID_CODE = 14'd15984;
  localparam logic [14:0] DIST_MAX     = 15'd15983;

  // w*16/58 == w*8/29 == (w * ceil(2^24/29)) >> 21, exact for w < 2^16
  localparam logic [19:0] DIST_RECIP = 20'd578525;
  localparam int          DIST_SHIFT = 21;

  // echo edge sampling, passed from the echo tracker to the result stage
  typedef struct packed {
    logic        done;
    logic [13:0] distance;
  } echo_stat_t;

endpackage

// ----- sv/uer_if.sv -----
interface uer_in_if;
  logic valid;
  logic ready;
  logic trigger_request;
  logic echo_level;

  modport source (output valid, output trigger_request, output echo_level, input ready);
  modport sink   (input valid, input trigger_request, input echo_level, output ready);
endinterface

interface uer_out_if;
  logic        valid;
  logic        ready;
  logic        trig_out;
  logic [13:0] distance_sixteenths;
  logic        obstacle;
  logic        measurement_done;

  modport source (output valid, output trig_out, output distance_sixteenths,
                  output obstacle, output measurement_done, input ready);
  modport sink   (input valid, input trig_out, input distance_sixteenths,
                  input obstacle, input measurement_done, output ready);
endinterface

// ----- sv/ultrasonic_echo_ranger.sv -----
// Ultrasonic echo ranger. Every input transaction is one microsecond tick
// (trigger request plus sampled echo level) and yields exactly one result
// transaction. A request fires a trigger pulse of pulse_us ticks when the
// hold-off from the last fired request has run out. Echo width is taken
// between rising and falling edges with a free-running COUNTER_BITS counter;
// widths strictly inside (min_echo_us, max_echo_us) map to width*16/58 in
// 1/16 cm, anything else (or a result above 15983) reads 15984 (999 cm).
// Rate: one tick per clock while the result side is not stalled. The whole
// state update (hold-off, pulse, edge stamp, width to distance via one
// 16x20 reciprocal multiply) sits between the input register and the
// result register. Config writes must happen while no ticks are in flight.
module ultrasonic_echo_ranger #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data,
  uer_in_if.sink                         in_ch,
  uer_out_if.source                      out_ch
);

  uer_pkg::cfg_t       cfg;
  uer_pkg::echo_stat_t stat;

  // input register
  logic s1_valid_r, s1_req_r, s1_echo_r;
  // result register
  logic        out_valid_r;
  logic        out_trig_r, out_obst_r, out_done_r;
  logic [13:0] out_dist_r;

  logic advance;  // s1 tick is processed and lands in the result register
  logic trig;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  uer_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  uer_trig u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .req   (s1_req_r),
    .cfg   (cfg),
    .trig  (trig)
  );

  uer_echo #(.CB(COUNTER_BITS)) u_echo (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .echo  (s1_echo_r),
    .cfg   (cfg),
    .stat  (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_req_r  <= in_ch.trigger_request;
      s1_echo_r <= in_ch.echo_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_trig_r <= trig;
      out_dist_r <= stat.distance;
      // held value compared as is, invalid code included
      out_obst_r <= (stat.distance <= cfg.obstacle_limit);
      out_done_r <= stat.done;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.trig_out            = out_trig_r;
  assign out_ch.distance_sixteenths = out_dist_r;
  assign out_ch.obstacle            = out_obst_r;
  assign out_ch.measurement_done    = out_done_r;

`ifndef SYNTH
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_dist_r <= uer_pkg::INVALID_CODE))
    else $error("distance above invalid code");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> s1_valid_r)
    else $error("stalled tick lost from input register");

  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> s1_valid_r)
    else $error("accepted transaction not captured");

  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed tick missing from result register");
`endif

endmodule

// ----- sv/uer_cfg.sv -----
module uer_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] data,
  output uer_pkg::cfg_t                  cfg
);

  uer_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.holdoff_us     <= uer_pkg::HOLDOFF_RST;
      cfg_r.pulse_us       <= uer_pkg::PULSE_RST;
      cfg_r.min_echo_us    <= uer_pkg::MIN_ECHO_RST;
      cfg_r.max_echo_us    <= uer_pkg::MAX_ECHO_RST;
      cfg_r.obstacle_limit <= uer_pkg::OBST_LIM_RST;
    end else if (we) begin
      unique case (uer_pkg::cfg_idx_t'(index))
        uer_pkg::CFG_HOLDOFF:  cfg_r.holdoff_us     <= data;
        uer_pkg::CFG_PULSE:    cfg_r.pulse_us       <= data[7:0];
        uer_pkg::CFG_MIN_ECHO: cfg_r.min_echo_us    <= data;
        uer_pkg::CFG_MAX_ECHO: cfg_r.max_echo_us    <= data;
        uer_pkg::CFG_OBST_LIM: cfg_r.obstacle_limit <= data[13:0];
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/uer_trig.sv -----
module uer_trig (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          req,
  input  uer_pkg::cfg_t cfg,
  output logic          trig
);

  logic [15:0] holdoff_r, holdoff_nxt, ho_dec;
  logic [7:0]  pulse_r, pulse_nxt, pl;
  logic        take;

  always_comb begin
    ho_dec      = (holdoff_r != 16'd0) ? holdoff_r - 16'd1 : 16'd0;
    take        = req && (ho_dec == 16'd0);
    holdoff_nxt = take ? cfg.holdoff_us : ho_dec;
    pl          = take ? cfg.pulse_us : pulse_r;
    trig        = (pl != 8'd0);
    pulse_nxt   = (pl != 8'd0) ? pl - 8'd1 : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdoff_r <= uer_pkg::HOLDOFF_RST;
      pulse_r   <= 8'd0;
    end else if (step) begin
      holdoff_r <= holdoff_nxt;
      pulse_r   <= pulse_nxt;
    end
  end

endmodule

// ----- sv/uer_dist.sv -----
module uer_dist #(
  parameter int CB = 16
) (
  input  logic [CB-1:0]     width,
  input  uer_pkg::cfg_t     cfg,
  output logic [13:0]       distance
);

  localparam int WB = (CB > 16) ? CB : 16;

  logic [WB-1:0] w_ext, min_ext, max_ext;
  logic          in_window;
  logic [35:0]   prod;
  logic [14:0]   q;

  always_comb begin
    w_ext     = WB'(width);
    min_ext   = WB'(cfg.min_echo_us);
    max_ext   = WB'(cfg.max_echo_us);
    in_window = (w_ext > min_ext) && (w_ext < max_ext);
    // inside the window the width is below 2^16
    prod      = 36'(w_ext[15:0]) * 36'(uer_pkg::DIST_RECIP);
    q         = prod[uer_pkg::DIST_SHIFT +: 15];
    if (!in_window || (q > uer_pkg::DIST_MAX)) begin
      distance = uer_pkg::INVALID_CODE;
    end else begin
      distance = q[13:0];
    end
  end

endmodule

// ----- sv/uer_echo.sv -----
module uer_echo #(
  parameter int CB = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                echo,
  input  uer_pkg::cfg_t       cfg,
  output uer_pkg::echo_stat_t stat
);

  logic [CB-1:0] count_r, stamp_r;
  logic          prev_r;
  logic [13:0]   dist_r;
  logic          rise, fall;
  logic [CB-1:0] width;
  logic [13:0]   dist_new;

  assign rise  = echo && !prev_r;
  assign fall  = !echo && prev_r;
  assign width = count_r - stamp_r;  // wraps mod 2^CB

  uer_dist #(.CB(CB)) u_dist (
    .width    (width),
    .cfg      (cfg),
    .distance (dist_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      stamp_r <= '0;
      prev_r  <= 1'b0;
      dist_r  <= uer_pkg::INVALID_CODE;
    end else if (step) begin
      count_r <= count_r + CB'(1);
      prev_r  <= echo;
      if (rise) stamp_r <= count_r;
      if (fall) dist_r  <= dist_new;
    end
  end

  always_comb begin
    stat.done     = fall;
    stat.distance = fall ? dist_new : dist_r;
  end

endmodule

// ----- dv/tb_ultrasonic_echo_ranger.sv -----
module tb_ultrasonic_echo_ranger;

  localparam int CNT_BITS = 16;

  // one microsecond tick as offered to the block
  typedef struct packed {
    logic req;
    logic echo;
  } tick_t;

  // one result transaction as the block should report it
  typedef struct packed {
    logic        trig;
    logic [13:0] distance;
    logic        obst;
    logic        done;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data;

  uer_in_if  in_ch ();
  uer_out_if out_ch ();

  ultrasonic_echo_ranger #(
    .COUNTER_BITS(CNT_BITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // Shadow copy of the registers and of the ranging state
  uer_pkg::cfg_t       ranger_cfg;
  logic [CNT_BITS-1:0] us_count;
  logic [CNT_BITS-1:0] edge_stamp;
  logic                echo_last;
  logic [15:0]         holdoff_run;
  logic [7:0]          pulse_run;
  logic [13:0]         range_held;

  tick_t    ticks_pending[$];
  reading_t readings_due[$];
  int       mismatches = 0;

  // driver / monitor pacing
  tick_t next_tick;
  int    in_gap = 0;
  int    calm_in = 0;
  int    out_stall = 0;
  int    calm_out = 0;

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Echo width -> distance in 1/16 cm. Only widths strictly inside the
  // window count; anything else, or a distance past 15983, is 999 cm.
  function automatic logic [13:0] span_to_sixteenths(logic [CNT_BITS-1:0] span);
    longint unsigned w;
    longint unsigned d;
    w = span;
    if (!(w > ranger_cfg.min_echo_us && w < ranger_cfg.max_echo_us))
      return uer_pkg::INVALID_CODE;
    d = (w * 16) / 58;
    if (d > uer_pkg::DIST_MAX)
      return uer_pkg::INVALID_CODE;
    return d[13:0];
  endfunction

  // One accepted tick: hold-off, trigger pulse, echo edges, in that order.
  task automatic advance_tick(logic req, logic echo);
    reading_t r;
    logic [CNT_BITS-1:0] span;
    if (holdoff_run != 0)
      holdoff_run--;
    // request honored only once the hold-off has run out; restarts the pulse
    if (req && holdoff_run == 0) begin
      holdoff_run = ranger_cfg.holdoff_us;
      pulse_run = ranger_cfg.pulse_us;
    end
    r.trig = (pulse_run != 0);
    if (pulse_run != 0)
      pulse_run--;
    r.done = 1'b0;
    if (echo && !echo_last) begin
      edge_stamp = us_count;
    end else if (!echo && echo_last) begin
      // difference wraps with the free-running counter
      span = us_count - edge_stamp;
      range_held = span_to_sixteenths(span);
      r.done = 1'b1;
    end
    echo_last = echo;
    us_count++;
    r.distance = range_held;
    // invalid code compared as is: flags only with a limit >= 15984
    r.obst = (range_held <= ranger_cfg.obstacle_limit);
    readings_due.push_back(r);
  endtask

  // mostly back to back, some short gaps, rare long ones
  function automatic int pick_idle();
    int r = $urandom_range(0, 999);
    if (r < 600) return 0;
    if (r < 900) return $urandom_range(1, 3);
    if (r < 985) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Driver: one tick per transaction from ticks_pending; the predictor
  // is advanced on the edge where the tick is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.trigger_request <= 1'b0;
      in_ch.echo_level <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        advance_tick(in_ch.trigger_request, in_ch.echo_level);
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (ticks_pending.size() > 0) begin
          next_tick = ticks_pending.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.trigger_request <= next_tick.req;
          in_ch.echo_level <= next_tick.echo;
          if (calm_in > 0) begin
            calm_in--;
          end else begin
            in_gap = pick_idle();
            if ($urandom_range(0, 199) == 0)
              calm_in = $urandom_range(100, 400);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_reading();
    reading_t want;
    if (readings_due.size() == 0) begin
      report_mismatch("result transaction with no tick pending");
      return;
    end
    want = readings_due.pop_front();
    if (out_ch.trig_out !== want.trig)
      report_mismatch($sformatf("trig_out got %b exp %b", out_ch.trig_out, want.trig));
    if (out_ch.distance_sixteenths !== want.distance)
      report_mismatch($sformatf("distance_sixteenths got %0d exp %0d",
                                out_ch.distance_sixteenths, want.distance));
    if (out_ch.obstacle !== want.obst)
      report_mismatch($sformatf("obstacle got %b exp %b", out_ch.obstacle, want.obst));
    if (out_ch.measurement_done !== want.done)
      report_mismatch($sformatf("measurement_done got %b exp %b",
                                out_ch.measurement_done, want.done));
  endtask

  // Monitor: checks every result transaction, stalls ready at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        check_reading();
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (calm_out > 0) begin
          calm_out--;
        end else if ($urandom_range(0, 3) == 0) begin
          out_stall = pick_idle();
        end else if ($urandom_range(0, 199) == 0) begin
          calm_out = $urandom_range(100, 400);
        end
      end
    end
  end

  task automatic push_tick(logic req, logic echo);
    tick_t t;
    t.req = req;
    t.echo = echo;
    ticks_pending.push_back(t);
  endtask

  // n ticks at one echo level, request with odds 1 in req_odds (0: none)
  task automatic queue_run(int n, logic echo, int req_odds);
    repeat (n)
      push_tick(req_odds != 0 && $urandom_range(1, req_odds) == 1, echo);
  endtask

  // Echo width aimed at the current window: inside, on each bound, or short.
  // Capped so that wide windows do not make the run long.
  function automatic int pick_width();
    int lo = ranger_cfg.min_echo_us;
    int hi = ranger_cfg.max_echo_us;
    int r = $urandom_range(0, 99);
    if (hi > 300) hi = 300;
    if (lo > 300) lo = 300;
    if (r < 50 && hi > lo + 1) return $urandom_range(lo + 1, hi - 1);
    if (r < 62) return (lo > 0) ? lo : 1;
    if (r < 74) return (hi > 0) ? hi : 1;
    return $urandom_range(1, 60);
  endfunction

  // Measurement sequences: request, quiet line, echo pulse; some glitch noise.
  task automatic queue_echo_train(int n_ticks);
    int made;
    int quiet;
    int w;
    made = 0;
    while (made < n_ticks) begin
      if ($urandom_range(0, 99) < 8) begin
        w = $urandom_range(1, 8);
        repeat (w) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        made += w;
      end
      quiet = $urandom_range(1, 12);
      push_tick($urandom_range(0, 9) < 7, 1'b0);
      queue_run(quiet - 1, 1'b0, 30);
      w = pick_width();
      queue_run(w, 1'b1, 30);
      made += quiet + w;
    end
  endtask

  task automatic write_reg(uer_pkg::cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    unique case (idx)
      uer_pkg::CFG_HOLDOFF:  ranger_cfg.holdoff_us = val;
      uer_pkg::CFG_PULSE:    ranger_cfg.pulse_us = val[7:0];
      uer_pkg::CFG_MIN_ECHO: ranger_cfg.min_echo_us = val;
      uer_pkg::CFG_MAX_ECHO: ranger_cfg.max_echo_us = val;
      uer_pkg::CFG_OBST_LIM: ranger_cfg.obstacle_limit = val[13:0];
      default: ;
    endcase
  endtask

  // block is idle whenever this is called
  task automatic set_config(logic [15:0] h, logic [7:0] p, logic [15:0] lo,
                            logic [15:0] hi, logic [13:0] ob);
    write_reg(uer_pkg::CFG_HOLDOFF, h);
    write_reg(uer_pkg::CFG_PULSE, 16'(p));
    write_reg(uer_pkg::CFG_MIN_ECHO, lo);
    write_reg(uer_pkg::CFG_MAX_ECHO, hi);
    write_reg(uer_pkg::CFG_OBST_LIM, 16'(ob));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every tick is taken and every result checked, plus latency
  task automatic drain();
    do @(negedge clk);
    while (ticks_pending.size() != 0 || in_ch.valid || readings_due.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic train_phase(logic [15:0] h, logic [7:0] p, logic [15:0] lo,
                             logic [15:0] hi, logic [13:0] ob);
    set_config(h, p, lo, hi, ob);
    @(negedge clk);
    queue_echo_train(130);
    drain();
  endtask

  task automatic random_phase();
    logic [15:0] h;
    logic [7:0]  p;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [13:0] ob;
    int r;
    r = $urandom_range(0, 3);
    h = (r == 0) ? 16'd0 : (r == 1) ? 16'd1 : 16'($urandom_range(2, 150));
    r = $urandom_range(0, 3);
    p = (r == 0) ? 8'd0 : (r == 1) ? 8'd1 : (r == 2) ? 8'd255 : 8'($urandom_range(2, 40));
    lo = $urandom_range(0, 150);
    hi = lo + 16'($urandom_range(0, 400));
    r = $urandom_range(0, 9);
    ob = (r == 0) ? 14'd15983 : (r == 1) ? 14'd15984 : 14'($urandom_range(0, 150));
    train_phase(h, p, lo, hi, ob);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = uer_pkg::CFG_HOLDOFF;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.trigger_request = 1'b0;
    in_ch.echo_level = 1'b0;
    out_ch.ready = 1'b0;

    ranger_cfg.holdoff_us = uer_pkg::HOLDOFF_RST;
    ranger_cfg.pulse_us = uer_pkg::PULSE_RST;
    ranger_cfg.min_echo_us = uer_pkg::MIN_ECHO_RST;
    ranger_cfg.max_echo_us = uer_pkg::MAX_ECHO_RST;
    ranger_cfg.obstacle_limit = uer_pkg::OBST_LIM_RST;
    us_count = '0;
    edge_stamp = '0;
    echo_last = 1'b0;
    holdoff_run = uer_pkg::HOLDOFF_RST;
    pulse_run = '0;
    range_held = uer_pkg::INVALID_CODE;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed echo widths against a tiny window (2, 10):
    // high on the very first tick so the stamp is the reset stamp,
    // then below the window, d=0 (obstacle at limit 0), d=1, upper bound.
    // Requests here are swallowed by the reset hold-off.
    set_config(uer_pkg::HOLDOFF_RST, uer_pkg::PULSE_RST, 16'd2, 16'd10, 14'd0);
    @(negedge clk);
    queue_run(1, 1'b1, 0);
    queue_run(1, 1'b0, 0);
    queue_run(3, 1'b1, 2);
    queue_run(1, 1'b0, 0);
    queue_run(7, 1'b1, 2);
    queue_run(1, 1'b0, 0);
    queue_run(10, 1'b1, 0);
    queue_run(1, 1'b0, 1);
    drain();

    // Longer echo under a wide-open window; limit 16383 flags the held
    // invalid code until the new distance lands. The reset hold-off of
    // 60000 ticks outlasts the run, so requests keep getting ignored.
    set_config(16'd37, 8'd5, 16'd10, 16'hFFFF, 14'd16383);
    @(negedge clk);
    queue_run(10, 1'b0, 16);
    queue_run($urandom_range(150, 250), 1'b1, 16);
    queue_run(5, 1'b0, 0);
    drain();

    // zero hold-off register; the reset hold-off still gates requests
    set_config(16'd0, 8'd3, 16'd0, 16'd400, 14'd60);
    @(negedge clk);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b0);
    drain();

    // zero pulse width: trigger line stays low
    set_config(16'd0, 8'd0, 16'd0, 16'd400, 14'd60);
    @(negedge clk);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    drain();

    // empty windows (max 0; min = max - 1), then width 1 valid
    train_phase(16'd1, 8'd1, 16'd0, 16'd0, 14'd0);
    train_phase(16'd20, 8'd255, 16'd50, 16'd51, 14'd16383);
    train_phase(16'd0, 8'd2, 16'd0, 16'd400, 14'd60);
    repeat (4) random_phase();
    // top of every register but the obstacle limit; invalid code sits exactly on the limit
    train_phase(16'hFFFF, 8'd255, 16'hFFFF, 16'hFFFF, 14'd15984);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // watchdog, far beyond the slowest legal pacing of ~2.5k ticks
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
